// ----- design/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and codes for the binary max-heap priority queue: entry
// layout, operation and status codes, controller command and status groups.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_W        = 32;
   localparam int PAY_W        = 32;
   localparam int OP_W         = 2;
   localparam int ST_W         = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;     // latch request beat
      logic stage_init;   // set result defaults and status code
      logic start_ins;    // hole at end of heap, count up
      logic rd_parent;    // read parent of hole on port a
      logic up_move;      // parent moves down into hole
      logic rd_root_last; // read root on port a, last entry on port b
      logic capture_root; // root goes to result
      logic start_del;    // last entry becomes sift item, hole at root
      logic rd_children;  // read children of hole on ports a and b
      logic dn_move;      // larger child moves up into hole
      logic write_cur;    // sift item lands in hole
      logic rsp_load;     // result to output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_ins;
      logic is_del;
      logic is_peek;
      logic empty;
      logic full;
      logic at_root;
      logic no_left;
      logic up_swap;
      logic dn_stop;
   } sts_type;

endpackage

// ----- design/bmhq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for the heap queue: decodes each request, walks the sift-up or
// sift-down loop level by level (read, compare) and hands off the result beat.
// ----------------------------------------------------------------------------
module bmhq_ctrl
   import bmhq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_UP_CHK = 3'd2;
   localparam logic [2:0] S_UP_CMP = 3'd3;
   localparam logic [2:0] S_ROOT   = 3'd4;
   localparam logic [2:0] S_DN_CHK = 3'd5;
   localparam logic [2:0] S_DN_CMP = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_busy;

   assign rsp_busy  = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.stage_init   = 1'b1;
            cmd.rd_root_last = 1'b1;
            if (sts.is_ins && !sts.full) begin
               cmd.start_ins = 1'b1;
               state_in      = S_UP_CHK;
            end else if ((sts.is_del || sts.is_peek) && !sts.empty) begin
               state_in = S_ROOT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_UP_CHK: begin
            if (sts.at_root) begin
               cmd.write_cur = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (sts.up_swap) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_CHK;
            end else begin
               cmd.write_cur = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_ROOT: begin
            cmd.capture_root = 1'b1;
            if (sts.is_del) begin
               cmd.start_del = 1'b1;
               state_in      = S_DN_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DN_CHK: begin
            if (sts.no_left) begin
               cmd.write_cur = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.rd_children = 1'b1;
               state_in        = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (sts.dn_stop) begin
               cmd.write_cur = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_CHK;
            end
         end
         S_FINISH: begin
            if (!rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_busy || cmd.rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/bmhq_dp.sv -----
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap datapath: entry memory with two registered read ports and one write
// port, the sift item and hole position, entry count and result registers.
// ----------------------------------------------------------------------------
module bmhq_dp
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int CW       = $clog2(CAPACITY + 1),
   parameter int AW       = $clog2(CAPACITY)
)
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [OP_W-1:0]  req_operation,
   input  logic [KEY_W-1:0] req_key_in,
   input  logic [PAY_W-1:0] req_payload_in,
   output logic [KEY_W-1:0] rsp_key_out,
   output logic [PAY_W-1:0] rsp_payload_out,
   output logic [ST_W-1:0]  rsp_status,
   output logic [CW-1:0]    rsp_count_out
);

   localparam int LW = AW + 2;

   entry_type        heap_store_ff [CAPACITY];
   entry_type        rd_a_ff, rd_b_ff;
   logic [AW-1:0]    rd_a_addr, rd_b_addr;
   logic             wr_en;
   entry_type        wr_data;

   logic [OP_W-1:0]  op_ff, op_in;
   entry_type        cur_ff, cur_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [KEY_W-1:0] res_key_ff, res_key_in;
   logic [PAY_W-1:0] res_pay_ff, res_pay_in;
   logic [ST_W-1:0]  res_stat_ff, res_stat_in;
   logic [KEY_W-1:0] out_key_ff, out_key_in;
   logic [PAY_W-1:0] out_pay_ff, out_pay_in;
   logic [ST_W-1:0]  out_stat_ff, out_stat_in;
   logic [CW-1:0]    out_cnt_ff, out_cnt_in;

   logic [AW-1:0]    parent;
   logic [LW-1:0]    left_w, right_w, cnt_w;
   logic [CW-1:0]    cnt_m1;
   logic             right_ok, pick_right;
   entry_type        pick;
   logic [AW-1:0]    pick_addr;

   assign parent     = (pos_ff - AW'(1)) >> 1;
   assign left_w     = {1'b0, pos_ff, 1'b1};
   assign right_w    = left_w + LW'(1);
   assign cnt_w      = LW'(count_ff);
   assign cnt_m1     = count_ff - CW'(1);
   assign right_ok   = right_w < cnt_w;
   assign pick_right = right_ok && (rd_b_ff.key > rd_a_ff.key);
   assign pick       = pick_right ? rd_b_ff : rd_a_ff;
   assign pick_addr  = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];

   assign sts.is_ins  = (op_ff == OP_INSERT);
   assign sts.is_del  = (op_ff == OP_DELETE);
   assign sts.is_peek = (op_ff == OP_PEEK);
   assign sts.empty   = (count_ff == '0);
   assign sts.full    = (count_ff == CW'(CAPACITY));
   assign sts.at_root = (pos_ff == '0);
   assign sts.no_left = (left_w >= cnt_w);
   assign sts.up_swap = (rd_a_ff.key < cur_ff.key);
   assign sts.dn_stop = (cur_ff.key > pick.key);

   // read address select
   always_comb begin
      rd_a_addr = left_w[AW-1:0];
      rd_b_addr = right_w[AW-1:0];
      if (cmd.rd_parent) begin
         rd_a_addr = parent;
      end else if (cmd.rd_root_last) begin
         rd_a_addr = '0;
         rd_b_addr = cnt_m1[AW-1:0];
      end else if (cmd.rd_children) begin
         rd_a_addr = left_w[AW-1:0];
         rd_b_addr = right_w[AW-1:0];
      end
   end

   // writes always land in the hole
   assign wr_en   = cmd.write_cur || cmd.up_move || cmd.dn_move;
   assign wr_data = cmd.write_cur ? cur_ff : (cmd.up_move ? rd_a_ff : pick);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_store_ff[pos_ff] <= wr_data;
      end
      rd_a_ff <= heap_store_ff[rd_a_addr];
      rd_b_ff <= heap_store_ff[rd_b_addr];
   end

   always_comb begin
      op_in       = op_ff;
      cur_in      = cur_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      res_key_in  = res_key_ff;
      res_pay_in  = res_pay_ff;
      res_stat_in = res_stat_ff;
      out_key_in  = out_key_ff;
      out_pay_in  = out_pay_ff;
      out_stat_in = out_stat_ff;
      out_cnt_in  = out_cnt_ff;
      if (cmd.load_req) begin
         op_in          = req_operation;
         cur_in.key     = req_key_in;
         cur_in.payload = req_payload_in;
      end
      if (cmd.stage_init) begin
         res_key_in  = '0;
         res_pay_in  = '0;
         res_stat_in = ST_OK;
         if (sts.is_ins && sts.full) begin
            res_stat_in = ST_FULL;
         end else if ((sts.is_del || sts.is_peek) && sts.empty) begin
            res_stat_in = ST_EMPTY;
         end
      end
      if (cmd.start_ins) begin
         pos_in   = count_ff[AW-1:0];
         count_in = count_ff + CW'(1);
      end
      if (cmd.up_move) begin
         pos_in = parent;
      end
      if (cmd.capture_root) begin
         res_key_in = rd_a_ff.key;
         res_pay_in = rd_a_ff.payload;
      end
      if (cmd.start_del) begin
         cur_in   = rd_b_ff;
         pos_in   = '0;
         count_in = cnt_m1;
      end
      if (cmd.dn_move) begin
         pos_in = pick_addr;
      end
      if (cmd.rsp_load) begin
         out_key_in  = res_key_ff;
         out_pay_in  = res_pay_ff;
         out_stat_in = res_stat_ff;
         out_cnt_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cur_ff      <= cur_in;
      pos_ff      <= pos_in;
      res_key_ff  <= res_key_in;
      res_pay_ff  <= res_pay_in;
      res_stat_ff <= res_stat_in;
      out_key_ff  <= out_key_in;
      out_pay_ff  <= out_pay_in;
      out_stat_ff <= out_stat_in;
      out_cnt_ff  <= out_cnt_in;
   end

   assign rsp_key_out     = out_key_ff;
   assign rsp_payload_out = out_pay_ff;
   assign rsp_status      = out_stat_ff;
   assign rsp_count_out   = out_cnt_ff;

endmodule

// ----- design/binary_max_heap_queue_top.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Fixed-capacity binary max-heap priority queue with insert, delete-max and
// peek-max requests, one result beat per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request beat (operation, key, payload); it is taken
//   when req_valid is high and req_stall is low. rsp_* returns exactly one
//   beat per request: root key/payload for delete or peek, a status code and
//   the entry count after the request.
//   Requests are handled one at a time. The heap lives in a memory with two
//   registered read ports; each heap level is a read, then a compare and
//   move. At 64 entries an insert moves at most 6 entries and a delete at
//   most 5, and the next request can be taken as soon as the result shows.
//   A finished result sits in an output register; the block accepts the
//   next request while it waits, and holds the following result back as
//   long as rsp_stall keeps the output register occupied.
//   Reset empties the queue at once (count to zero, no memory sweep) and
//   drops any result beat not yet taken.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_top
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int CW       = $clog2(CAPACITY + 1)
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [OP_W-1:0]  req_operation,
   input  logic [KEY_W-1:0] req_key_in,
   input  logic [PAY_W-1:0] req_payload_in,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [KEY_W-1:0] rsp_key_out,
   output logic [PAY_W-1:0] rsp_payload_out,
   output logic [ST_W-1:0]  rsp_status,
   output logic [CW-1:0]    rsp_count_out
);

   cmd_type cmd;
   sts_type sts;

   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   bmhq_dp #(
      .CAPACITY (CAPACITY),
      .CW       (CW),
      .AW       ($clog2(CAPACITY))
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_operation),
      .req_key_in      (req_key_in),
      .req_payload_in  (req_payload_in),
      .rsp_key_out     (rsp_key_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_status      (rsp_status),
      .rsp_count_out   (rsp_count_out)
   );

endmodule

// ----- design/bmhq_chk.sv -----
// ----------------------------------------------------------------------------
// bmhq_chk
// Port-level checks for the heap queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bmhq_chk
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int CW       = $clog2(CAPACITY + 1)
)
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic [OP_W-1:0]  req_operation,
   input logic [KEY_W-1:0] req_key_in,
   input logic [PAY_W-1:0] req_payload_in,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [KEY_W-1:0] rsp_key_out,
   input logic [PAY_W-1:0] rsp_payload_out,
   input logic [ST_W-1:0]  rsp_status,
   input logic [CW-1:0]    rsp_count_out
);

   // one request in flight: busy right after a beat is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in flight");

   // a stalled request beat keeps its content
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_operation)
         && $stable(req_key_in) && $stable(req_payload_in)))
      else $error("stalled request beat changed");

   // a held result beat keeps its content
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_key_out)
         && $stable(rsp_payload_out) && $stable(rsp_status)
         && $stable(rsp_count_out)))
      else $error("stalled result beat changed");

   // error results carry no entry
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_key_out == '0 && rsp_payload_out == '0))
      else $error("error result with nonzero entry");

   // full only at capacity, empty only at zero
   a_count_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status != ST_FULL || rsp_count_out == CW'(CAPACITY))
         && (rsp_status != ST_EMPTY || rsp_count_out == '0)
         && (rsp_count_out <= CW'(CAPACITY))))
      else $error("count does not match status");

endmodule

bind binary_max_heap_queue_top bmhq_chk #(
   .CAPACITY (CAPACITY),
   .CW       (CW)
) u_bmhq_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_operation   (req_operation),
   .req_key_in      (req_key_in),
   .req_payload_in  (req_payload_in),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_key_out     (rsp_key_out),
   .rsp_payload_out (rsp_payload_out),
   .rsp_status      (rsp_status),
   .rsp_count_out   (rsp_count_out)
);

// ----- verif/binary_max_heap_queue_top_tb.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top_tb
// Self-checking bench for the max-heap priority queue. A short table of
// requests covers the empty, extreme and equal-key cases. Random traffic
// follows, cycling the heap between full and empty with idle gaps and
// result stalls. Every result beat is compared with an in-bench copy of the
// heap or, for pinned table rows, with the typed-in result.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_top_tb;
   import bmhq_pkg::*;

   localparam int HEAP_DEPTH  = CAPACITY_DEF;
   localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);
   localparam int NUM_ROWS    = 21;
   localparam int NUM_RANDOM  = 1880;
   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_WAIT  = 30;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
      logic [ST_W-1:0]  status;
      logic [CNT_W-1:0] count;
   } heap_reply_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
      logic             pinned;
      heap_reply_type   reply;
   } script_row_type;

   typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIXED} load_mode_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [OP_W-1:0]  req_operation;
   logic [KEY_W-1:0] req_key_in;
   logic [PAY_W-1:0] req_payload_in;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [KEY_W-1:0] rsp_key_out;
   logic [PAY_W-1:0] rsp_payload_out;
   logic [ST_W-1:0]  rsp_status;
   logic [CNT_W-1:0] rsp_count_out;

   // typed-in result that rides along with the current request beat
   logic             req_pinned;
   heap_reply_type   req_pinned_reply;

   entry_type        heap_mem [HEAP_DEPTH];
   int unsigned      heap_count;
   heap_reply_type   pending_replies [$];
   int unsigned      error_count;
   int unsigned      idle_cycles;
   logic             calm;
   int unsigned      rsp_run;

   script_row_type script [NUM_ROWS] = '{
      '{OP_PEEK,   32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, ST_EMPTY, 7'd0}},
      '{OP_DELETE, 32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, ST_EMPTY, 7'd0}},
      '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, ST_OK, 7'd0}},
      '{OP_INSERT, 32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, ST_OK, 7'd1}},
      '{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, ST_OK, 7'd2}},
      '{OP_PEEK,   32'h0,         32'h0,         1'b1,
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_OK, 7'd2}},
      '{OP_INSERT, 32'h8000_0000, 32'h5555_5555, 1'b0, '0},
      '{OP_INSERT, 32'h8000_0000, 32'hAAAA_AAAA, 1'b0, '0},
      '{OP_INSERT, 32'h8000_0000, 32'h0000_0001, 1'b0, '0},
      '{OP_INSERT, 32'h0000_0001, 32'h0F0F_0F0F, 1'b0, '0},
      '{OP_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
      '{OP_DELETE, 32'h0,         32'h0,         1'b1,
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_OK, 7'd5}},
      '{OP_PEEK,   32'h0,         32'h0,         1'b0, '0},
      '{OP_DELETE, 32'h0,         32'h0,         1'b0, '0},
      '{OP_DELETE, 32'h0,         32'h0,         1'b0, '0},
      '{OP_DELETE, 32'h0,         32'h0,         1'b0, '0},
      '{OP_DELETE, 32'h0,         32'h0,         1'b0, '0},
      '{OP_DELETE, 32'h0,         32'h0,         1'b0, '0},
      '{OP_DELETE, 32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, ST_EMPTY, 7'd0}},
      '{OP_PEEK,   32'h0,         32'h0,         1'b1, '{32'h0, 32'h0, ST_EMPTY, 7'd0}},
      '{OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0}
   };

   binary_max_heap_queue_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_key_in      (req_key_in),
      .req_payload_in  (req_payload_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_out     (rsp_key_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_status      (rsp_status),
      .rsp_count_out   (rsp_count_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one request to the bench copy of the heap and return its result
   function automatic heap_reply_type run_heap_op(input logic [OP_W-1:0] op,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [PAY_W-1:0] payload);
      heap_reply_type reply;
      entry_type   tmp;
      int unsigned pos;
      int unsigned parent;
      int unsigned left;
      int unsigned right;
      int unsigned pick;
      reply = '0;
      reply.status = ST_OK;
      if (op == OP_INSERT) begin
         if (heap_count >= HEAP_DEPTH) begin
            reply.status = ST_FULL;
         end else begin
            pos = heap_count;
            heap_mem[pos] = '{key: key, payload: payload};
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (!(heap_mem[parent].key < heap_mem[pos].key)) break;
               tmp = heap_mem[parent];
               heap_mem[parent] = heap_mem[pos];
               heap_mem[pos] = tmp;
               pos = parent;
            end
            heap_count++;
         end
      end else if (op == OP_DELETE || op == OP_PEEK) begin
         if (heap_count == 0) begin
            reply.status = ST_EMPTY;
         end else begin
            reply.key = heap_mem[0].key;
            reply.payload = heap_mem[0].payload;
            if (op == OP_DELETE) begin
               heap_count--;
               heap_mem[0] = heap_mem[heap_count];
               pos = 0;
               // equal keys keep sinking: only a strictly larger parent stops
               while (2 * pos + 1 < heap_count) begin
                  left = 2 * pos + 1;
                  right = left + 1;
                  pick = left;
                  if (right < heap_count && heap_mem[right].key > heap_mem[left].key)
                     pick = right;
                  if (heap_mem[pos].key > heap_mem[pick].key) break;
                  tmp = heap_mem[pos];
                  heap_mem[pos] = heap_mem[pick];
                  heap_mem[pick] = tmp;
                  pos = pick;
               end
            end
         end
      end
      reply.count = heap_count[CNT_W-1:0];
      return reply;
   endfunction

   // idle length: mostly none, often short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [OP_W-1:0] pick_operation(input load_mode_type mode);
      int unsigned r;
      int unsigned ins_pct;
      int unsigned del_pct;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            ins_pct = 75;
            del_pct = 10;
         end
         MODE_DRAIN: begin
            ins_pct = 15;
            del_pct = 65;
         end
         default: begin
            ins_pct = 45;
            del_pct = 40;
         end
      endcase
      if (r < ins_pct) return OP_INSERT;
      if (r < ins_pct + del_pct) return OP_DELETE;
      if (r < 96) return OP_PEEK;
      return OP_UNUSED;
   endfunction

   // narrow keys give plenty of ties, extremes hit the compare edges
   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom;
      if (r < 90) return $urandom_range(0, 15);
      case ($urandom_range(0, 2))
         0: return '0;
         1: return '1;
         default: return 32'h8000_0000;
      endcase
   endfunction

   task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [PAY_W-1:0] payload, input logic pinned,
                            input heap_reply_type reply);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_key_in <= key;
      req_payload_in <= payload;
      req_pinned <= pinned;
      req_pinned_reply <= reply;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // result side stall pattern
   always @(negedge clock) begin
      logic hold;
      if (rsp_run > 0) begin
         rsp_run--;
      end else begin
         hold = !calm && $urandom_range(0, 2) == 0;
         rsp_stall <= hold;
         rsp_run = hold ? ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3))
                        : $urandom_range(1, 6);
      end
   end

   // accept beats on both channels, predict and compare, watch for a hang
   always @(posedge clock) begin : scoreboard
      heap_reply_type want;
      logic           moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            want = run_heap_op(req_operation, req_key_in, req_payload_in);
            pending_replies.push_back(req_pinned ? req_pinned_reply : want);
            moved = 1'b1;
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            moved = 1'b1;
            if (pending_replies.size() == 0) begin
               $error("result beat with no request pending");
               error_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_key_out !== want.key) begin
                  $error("key_out: expected %h, got %h", want.key, rsp_key_out);
                  error_count++;
               end
               if (rsp_payload_out !== want.payload) begin
                  $error("payload_out: expected %h, got %h", want.payload,
                         rsp_payload_out);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_count_out !== want.count) begin
                  $error("count_out: expected %0d, got %0d", want.count, rsp_count_out);
                  error_count++;
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("binary_max_heap_queue_top_tb: errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      load_mode_type   mode;
      logic [OP_W-1:0] op;
      heap_reply_type  none;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_INSERT;
      req_key_in = '0;
      req_payload_in = '0;
      req_pinned = 1'b0;
      req_pinned_reply = '0;
      rsp_stall = 1'b0;
      rsp_run = 0;
      calm = 1'b0;
      heap_count = 0;
      error_count = 0;
      idle_cycles = 0;
      none = '0;
      mode = MODE_FILL;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         @(negedge clock);
         send_beat(script[i].op, script[i].key, script[i].payload, script[i].pinned,
                   script[i].reply);
      end

      for (int i = 0; i < NUM_RANDOM; i++) begin
         @(negedge clock);
         // swing the heap between full and empty so overflow and underflow recur
         if (heap_count == HEAP_DEPTH && mode != MODE_DRAIN && $urandom_range(0, 3) == 0)
            mode = MODE_DRAIN;
         else if (heap_count == 0 && mode == MODE_DRAIN && $urandom_range(0, 2) == 0)
            mode = $urandom_range(0, 1) ? MODE_FILL : MODE_MIXED;
         else if (mode == MODE_MIXED && $urandom_range(0, 59) == 0)
            mode = MODE_FILL;
         if ($urandom_range(0, 99) == 0) calm = !calm;
         op = pick_operation(mode);
         send_beat(op, pick_key(), $urandom, 1'b0, none);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      calm = 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("binary_max_heap_queue_top_tb: clean");
      else
         $display("binary_max_heap_queue_top_tb: errors");
      $finish;
   end

endmodule

// ----- files.f -----
design/bmhq_pkg.sv
design/bmhq_ctrl.sv
design/bmhq_dp.sv
design/binary_max_heap_queue_top.sv
design/bmhq_chk.sv
verif/binary_max_heap_queue_top_tb.sv
